>>> sv/sha512_384_stream_hash_top_macros.svh
// assertion macros for the sha-512/384 stream hash
`ifndef SHA512_384_STREAM_HASH_TOP_MACROS_SVH
`define SHA512_384_STREAM_HASH_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sha_pkg.sv
// shared types, constants and round functions for the sha-512/384 hash
`default_nettype none
package sha_pkg;

  // control from the sequencer to the compression core
  typedef struct packed {
    logic       push;
    logic [7:0] byte_in;
    logic       start;
    logic       load_init;
    logic       variant;
  } core_ctrl_t;

  typedef logic [7:0][63:0] hash_vec_t;

  localparam int unsigned Rounds = 80;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [6:0] PadLimit = 7'd112;
  localparam logic [6:0] LenPos = 7'd120;

  localparam logic [63:0] RoundK [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam hash_vec_t Init512 = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  localparam hash_vec_t Init384 = {
    64'h47b5481dbefa4fa4, 64'hdb0c2e0d64f98fa7, 64'h8eb44a8768581511, 64'h67332667ffc00b31,
    64'h152fecd8f70e5939, 64'h9159015a3070dd17, 64'h629a292a367cd507, 64'hcbbb9d5dc1059ed8
  };

  function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (64 - n));
  endfunction

endpackage
`default_nettype wire

>>> sv/sha_core.sv
// sha-512 compression core: byte-loaded schedule window and one shared round unit
`default_nettype none
module sha_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sha_pkg::core_ctrl_t ctrl,
  output logic                    done,
  output sha_pkg::hash_vec_t      hash
);
  import sha_pkg::*;

  logic [15:0][63:0] w;
  logic [63:0] a, b, c, d, e, f, g, h;
  logic [6:0] rnd;
  logic       busy;
  logic       fin;

  logic [63:0] s0, s1, chs, maj, t1, t2, sig0, sig1, w_new;

  // round and schedule arithmetic, w[15] is the word of the current round
  always_comb begin
    s1    = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
    chs   = (e & f) ^ (~e & g);
    t1    = h + s1 + chs + RoundK[rnd] + w[15];
    s0    = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
    maj   = (a & b) ^ (a & c) ^ (b & c);
    t2    = s0 + maj;
    sig0  = rotr(w[14], 1) ^ rotr(w[14], 8) ^ (w[14] >> 7);
    sig1  = rotr(w[1], 19) ^ rotr(w[1], 61) ^ (w[1] >> 6);
    w_new = w[15] + sig0 + w[6] + sig1;
  end

  // schedule window: bytes shift in at the bottom, rounds shift words up
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      w <= {w[15][55:0], w[14][63:56], w[14][55:0], w[13][63:56],
            w[13][55:0], w[12][63:56], w[12][55:0], w[11][63:56],
            w[11][55:0], w[10][63:56], w[10][55:0], w[9][63:56],
            w[9][55:0], w[8][63:56], w[8][55:0], w[7][63:56],
            w[7][55:0], w[6][63:56], w[6][55:0], w[5][63:56],
            w[5][55:0], w[4][63:56], w[4][55:0], w[3][63:56],
            w[3][55:0], w[2][63:56], w[2][55:0], w[1][63:56],
            w[1][55:0], w[0][63:56], w[0][55:0], ctrl.byte_in};
    end else if (busy) begin
      w <= {w[14:0], w_new};
    end
  end

  // round counter and finishing add
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      rnd  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      fin  <= 1'b0;
      rnd  <= '0;
    end else if (busy) begin
      if (rnd == 7'(Rounds - 1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
      rnd <= rnd + 7'd1;
    end else begin
      fin <= 1'b0;
    end
  end

  assign done = fin;

  // working variables
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      {h, g, f, e, d, c, b, a} <= hash;
    end else if (busy) begin
      h <= g;
      g <= f;
      f <= e;
      e <= d + t1;
      d <= c;
      c <= b;
      b <= a;
      a <= t1 + t2;
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= Init512;
    end else if (ctrl.load_init) begin
      hash <= ctrl.variant ? Init384 : Init512;
    end else if (fin) begin
      hash[0] <= hash[0] + a;
      hash[1] <= hash[1] + b;
      hash[2] <= hash[2] + c;
      hash[3] <= hash[3] + d;
      hash[4] <= hash[4] + e;
      hash[5] <= hash[5] + f;
      hash[6] <= hash[6] + g;
      hash[7] <= hash[7] + h;
    end
  end

endmodule
`default_nettype wire

>>> sv/sha512_384_stream_hash_top.sv
// Streaming SHA-512 / SHA-384 hash. One message byte enters per word on the
// slave side; s_tlast closes the message and s_tuser marks that s_tdata holds
// a byte. The slave side is held off while each full 128-byte block runs
// through the 80 rounds of the single shared round unit and the chaining
// add. Closing a message feeds the padding bytes one per cycle, except while
// a block compresses, through the same byte path, one or two more
// compressions, then the digest as 6 (SHA-384) or 8 (SHA-512) 64-bit words on
// the master side, word_index in m_tuser and m_tlast on the final word. The
// cfg channel selects the variant and restarts the message; it is ready only
// while idle, and a pending cfg word holds off the slave side for that cycle.
`default_nettype none
`include "sha512_384_stream_hash_top_macros.svh"
module sha512_384_stream_hash_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,     // variant_384
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,      // data_byte
  input  wire logic        s_tuser,      // byte_present
  input  wire logic        s_tlast,      // message_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,      // digest_word
  output logic [2:0]       m_tuser,      // word_index
  output logic             m_tlast       // last_word
);
  import sha_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StComp = 2'd1;
  localparam logic [1:0] StPad  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  state;
  logic        variant;
  logic [6:0]  fill;
  logic [63:0] msg_len;
  logic [63:0] bit_len;
  logic        end_pend;
  logic        pad_first;
  logic        pad_two;
  logic        final_blk;
  logic [2:0]  idx;

  core_ctrl_t  ctrl;
  logic        core_done;
  hash_vec_t   hash;

  logic        in_acc, cfg_acc, out_acc;
  logic [7:0]  pad_byte;
  logic [63:0] len_inc;

  assign cfg_ready = (state == StIdle);
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign s_tready  = (state == StIdle) & ~cfg_valid;
  assign in_acc    = s_tvalid & s_tready;
  assign m_tvalid  = (state == StOut);
  assign out_acc   = m_tvalid & m_tready;
  assign m_tdata   = hash[idx];
  assign m_tuser   = idx;
  assign m_tlast   = variant ? (idx == 3'd5) : (idx == 3'd7);
  assign len_inc   = msg_len + {63'd0, s_tuser};

  // padding byte for the current fill position
  always_comb begin
    if (pad_first) begin
      pad_byte = PadByte;
    end else if (fill >= LenPos && !pad_two) begin
      pad_byte = bit_len[8'd63 - {2'd0, fill[2:0], 3'd0} -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // byte path and core control
  always_comb begin
    ctrl.variant   = cfg_acc ? cfg_data : variant;
    ctrl.load_init = cfg_acc | (out_acc & m_tlast);
    ctrl.push      = (in_acc & s_tuser) | (state == StPad);
    ctrl.byte_in   = (state == StPad) ? pad_byte : s_tdata;
    ctrl.start     = ctrl.push & (fill == 7'd127);
  end

  sha_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .done (core_done),
    .hash (hash)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      variant   <= 1'b0;
      fill      <= '0;
      msg_len   <= '0;
      end_pend  <= 1'b0;
      pad_first <= 1'b0;
      pad_two   <= 1'b0;
      final_blk <= 1'b0;
      idx       <= '0;
    end else begin
      if (ctrl.push) begin
        fill <= fill + 7'd1;
      end
      unique case (state)
        StIdle: begin
          if (in_acc) begin
            msg_len   <= len_inc;
            bit_len   <= {len_inc[60:0], 3'd0};
            end_pend  <= s_tlast;
            pad_first <= 1'b1;
            final_blk <= 1'b0;
            if (ctrl.start) begin
              state <= StComp;
            end else if (s_tlast) begin
              state <= StPad;
            end
          end
        end
        StPad: begin
          pad_first <= 1'b0;
          if (ctrl.start) begin
            final_blk <= pad_first ? (fill < PadLimit) : !pad_two;
            pad_two   <= 1'b0;
            state     <= StComp;
          end else if (pad_first) begin
            pad_two <= (fill >= PadLimit);
          end
        end
        StComp: begin
          if (core_done) begin
            if (final_blk) begin
              idx   <= '0;
              state <= StOut;
            end else if (end_pend) begin
              state <= StPad;
            end else begin
              state <= StIdle;
            end
          end
        end
        StOut: begin
          if (out_acc) begin
            idx <= idx + 3'd1;
            if (m_tlast) begin
              state    <= StIdle;
              end_pend <= 1'b0;
              msg_len  <= '0;
            end
          end
        end
        default: state <= StIdle;
      endcase
      if (cfg_acc) begin
        variant <= cfg_data;
        fill    <= '0;
        msg_len <= '0;
      end
    end
  end

  // checks
  `SHA_ASSERT_NOW(a_done_in_comp, core_done, state == StComp, "core done outside compression")
  `SHA_ASSERT_NOW(a_out_fill_zero, m_tvalid, fill == 7'd0, "digest out with partial block")
  `SHA_ASSERT_NOW(a_last_index, m_tvalid && m_tlast, m_tuser == 3'd5 || m_tuser == 3'd7, "bad last index")
  `SHA_ASSERT_NEXT(a_last_reload, out_acc && m_tlast, state == StIdle && msg_len == 64'd0, "no restart after digest")

endmodule
`default_nettype wire

>>> verif/sha512_384_stream_hash_top_tb.sv
// self-checking testbench for the streaming sha-512/384 hash: byte stream in, digest words out
`timescale 1ns / 100ps
module sha512_384_stream_hash_top_tb;
  import sha_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       fin;
  } msg_item_t;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        cfg_ready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // data_byte
  logic        s_tuser = 1'b0;    // byte_present
  logic        s_tlast = 1'b0;    // message_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // digest_word
  logic [2:0]  m_tuser;           // word_index
  logic        m_tlast;           // last_word

  msg_item_t    pending_bytes[$];
  digest_word_t pending_digest[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  err_count = 0;

  // shadow hash state
  logic        use_384 = 1'b0;
  logic [63:0] chain[8];
  logic [7:0]  blk[128];
  int unsigned fill;
  logic [63:0] msg_len;

  sha512_384_stream_hash_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  initial forever #4 clk = ~clk;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [63:0] ror64(input logic [63:0] v, input int n);
    ror64 = (v >> n) | (v << (64 - n));
  endfunction

  task automatic restart_chain();
    for (int i = 0; i < 8; i++) chain[i] = use_384 ? Init384[i] : Init512[i];
    fill = 0;
    msg_len = '0;
  endtask

  // 80 rounds over the buffered block, added into the chaining value
  task automatic compress_block();
    logic [63:0] w[16];
    logic [63:0] a, b, c, d, e, f, g, h, t1, t2, x15, x2;
    for (int t = 0; t < 16; t++)
      for (int j = 0; j < 8; j++) w[t] = {w[t][55:0], blk[8 * t + j]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        x15 = w[(t - 15) & 15];
        x2 = w[(t - 2) & 15];
        w[t & 15] = w[t & 15] + (ror64(x15, 1) ^ ror64(x15, 8) ^ (x15 >> 7))
                  + w[(t - 7) & 15] + (ror64(x2, 19) ^ ror64(x2, 61) ^ (x2 >> 6));
      end
      t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
         + RoundK[t] + w[t & 15];
      t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  // absorb one accepted word and queue the digest it closes, if any
  task automatic absorb_word(input logic [7:0] data, input logic has_byte, input logic fin);
    logic [63:0] bits;
    int unsigned n;
    digest_word_t dw;
    if (has_byte) begin
      blk[fill] = data;
      fill++;
      msg_len++;
      if (fill == 128) begin
        compress_block();
        fill = 0;
      end
    end
    if (fin) begin
      bits = msg_len << 3;
      blk[fill] = PadByte;
      fill++;
      if (fill > PadLimit) begin
        for (int i = fill; i < 128; i++) blk[i] = 8'h00;
        compress_block();
        fill = 0;
      end
      for (int i = fill; i < LenPos; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[LenPos + i] = bits[63 - 8 * i -: 8];
      compress_block();
      n = use_384 ? 6 : 8;
      for (int i = 0; i < n; i++) begin
        dw.word = chain[i];
        dw.idx = i[2:0];
        dw.last = (i + 1 == n);
        pending_digest = {pending_digest, dw};
      end
      restart_chain();
    end
  endtask

  // slave-side driver
  always @(posedge clk) begin
    msg_item_t it;
    if (!rst) begin
      if (s_tvalid && s_tready) absorb_word(s_tdata, s_tuser, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= it.data;
          s_tuser <= it.has_byte;
          s_tlast <= it.fin;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // master-side monitor and backpressure
  always @(posedge clk) begin
    digest_word_t want;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_digest.size() == 0) begin
        $display("%0t unexpected digest word: got %h idx %0d last %0b",
                 $time, m_tdata, m_tuser, m_tlast);
        err_count++;
      end else begin
        want = pending_digest.pop_front();
        if (m_tdata !== want.word || m_tuser !== want.idx || m_tlast !== want.last) begin
          $display("%0t digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                   $time, want.word, want.idx, want.last, m_tdata, m_tuser, m_tlast);
          err_count++;
        end
      end
    end
  end

  task automatic push_word(input logic [7:0] data, input logic has_byte, input logic fin);
    msg_item_t it;
    it.data = data;
    it.has_byte = has_byte;
    it.fin = fin;
    pending_bytes = {pending_bytes, it};
  endtask

  // message of random bytes with idle words mixed in; the end either rides on the last byte or comes alone
  task automatic push_message(input int unsigned len);
    bit end_alone;
    end_alone = (len == 0) || $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) push_word(8'($urandom_range(255)), 1'b0, 1'b0);
      push_word(8'($urandom_range(255)), 1'b1, !end_alone && (i == len - 1));
    end
    if (end_alone) push_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_bytes.size() != 0 || s_tvalid || pending_digest.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_variant(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    use_384 = v;
    restart_chain();
  endtask

  initial begin
    int unsigned boundary_len[6] = '{111, 112, 119, 127, 128, 129};
    use_384 = 1'b0;
    restart_chain();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty messages, short strings, idle words, extreme bytes
    write_variant(1'b0);
    push_word(8'hff, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    push_word("a", 1'b1, 1'b0);
    push_word("b", 1'b1, 1'b0);
    push_word("c", 1'b1, 1'b1);
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'hff, 1'b1, 1'b0);
    push_word(8'h55, 1'b0, 1'b1);
    wait_drained();
    write_variant(1'b1);
    push_word(8'hff, 1'b0, 1'b1);
    push_word("a", 1'b1, 1'b0);
    push_word("b", 1'b1, 1'b0);
    push_word("c", 1'b1, 1'b1);
    push_word(8'hff, 1'b1, 1'b1);
    push_word(8'h00, 1'b1, 1'b0);
    wait_drained();

    // random phases under different idling patterns
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      write_variant(p[0]);
      // padding boundaries in the first and last phase
      if (p == 0 || p == 3) push_message(boundary_len[$urandom_range(5)]);
      while (pending_bytes.size() < 70) begin
        push_message($urandom_range(4) == 0 ? 0 : $urandom_range(20));
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
